@@ rtl/core/pscc_pkg.sv @@
package pscc_pkg;

    localparam int ACT_W  = 2;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_action ACT_BEGIN = 2'd0;
    localparam t_action ACT_READ  = 2'd1;
    localparam t_action ACT_WRITE = 2'd2;

    localparam t_mode MODE_EXCL  = 2'd0;
    localparam t_mode MODE_CREAD = 2'd1;
    localparam t_mode MODE_CCW   = 2'd2;

    typedef struct packed {
        t_action                   action;
        logic [ADDR_W-1:0]         address;
        logic signed [DATA_W-1:0]  write_value;
    } t_in_beat;

    typedef struct packed {
        logic              clear;
        logic              record;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] match_value;
        logic [DATA_W-1:0] record_value;
    } t_store_ctl;

    typedef struct packed {
        logic hit;
        logic value_match;
        logic full;
    } t_store_sts;

endpackage

@@ rtl/core/pscc_if.sv @@
interface pscc_in_if import pscc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_action                  action;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_value;

    modport source (output valid, output action, output address, output write_value,
                    input ready);
    modport sink   (input valid, input action, input address, input write_value,
                    output ready);
endinterface

interface pscc_out_if ();
    logic valid;
    logic ready;
    logic violation;
    logic store_full;

    modport source (output valid, output violation, output store_full, input ready);
    modport sink   (input valid, input violation, input store_full, output ready);
endinterface

@@ rtl/core/pscc_store.sv @@
module pscc_store import pscc_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    output t_store_sts o_sts
);

    localparam int CW = $clog2(ENTRIES + 1);

    logic [CW-1:0]     r_count;
    logic [ADDR_W-1:0] r_entry_addr [ENTRIES];
    logic [DATA_W-1:0] r_entry_val  [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_val_eq;

    // entries are filled in order, so an entry is in use exactly when below the count
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_ctl.record && r_count == CW'(i)) begin
                r_entry_addr[i] <= i_ctl.address;
                r_entry_val[i]  <= i_ctl.record_value;
            end
        end

        assign w_match[i]  = (CW'(i) < r_count) && (r_entry_addr[i] == i_ctl.address);
        assign w_val_eq[i] = (r_entry_val[i] == i_ctl.match_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.record) begin
            r_count <= r_count + 1'b1;
        end
    end

    // an address is held at most once, so the value match belongs to the one hit
    assign o_sts.hit         = |w_match;
    assign o_sts.value_match = |(w_match & w_val_eq);
    assign o_sts.full        = (r_count == CW'(ENTRIES));

endmodule

@@ rtl/core/parallel_step_access_conflict_check.sv @@
// channel   | dir | beat contents
// ----------+-----+------------------------------------------
// i_in      | in  | action, address, write_value
// o_out     | out | violation, store_full
// i_cfg_*   | in  | access_mode write, no handshake
//
// one beat per cycle sustained while o_out is not stalled; a beat passes the
// input register, then the result register. the match over all entries is
// combinational between them; the store updates as the beat enters the result
// register. reset is synchronous; the store empties by its count.
// a stalled result holds the result register and, behind it, the input register.
module parallel_step_access_conflict_check import pscc_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    pscc_in_if.sink           i_in,
    pscc_out_if.source        o_out
);

    t_mode      r_mode;
    logic       r_in_valid;
    t_in_beat   r_in_beat;
    logic       r_out_valid;
    logic       r_out_viol;
    logic       r_out_full;

    logic       w_adv;
    logic       w_viol;
    logic       w_full;
    logic       w_rec;
    logic       w_begin;
    logic [DATA_W-1:0] w_rec_val;
    t_store_ctl w_ctl;
    t_store_sts w_sts;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CREAD;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_beat.action      <= i_in.action;
            r_in_beat.address     <= i_in.address;
            r_in_beat.write_value <= i_in.write_value;
        end
    end

    always_comb begin
        w_viol    = 1'b0;
        w_full    = 1'b0;
        w_rec     = 1'b0;
        w_begin   = 1'b0;
        w_rec_val = '0;
        unique case (r_in_beat.action)
            ACT_BEGIN: begin
                w_begin = 1'b1;
            end
            ACT_READ: begin
                if (r_mode == MODE_EXCL) begin
                    if (w_sts.hit) begin
                        w_viol = 1'b1;
                    end else if (w_sts.full) begin
                        w_full = 1'b1;
                    end else begin
                        w_rec = 1'b1;
                    end
                end
            end
            ACT_WRITE: begin
                w_rec_val = r_in_beat.write_value;
                if (w_sts.hit) begin
                    w_viol = !(r_mode == MODE_CCW && w_sts.value_match);
                end else if (w_sts.full) begin
                    w_full = 1'b1;
                end else begin
                    w_rec = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // store changes only when the beat moves on to the result register
    assign w_ctl.clear        = w_adv && r_in_valid && w_begin;
    assign w_ctl.record       = w_adv && r_in_valid && w_rec;
    assign w_ctl.address      = r_in_beat.address;
    assign w_ctl.match_value  = r_in_beat.write_value;
    assign w_ctl.record_value = w_rec_val;

    pscc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out_viol <= w_viol;
            r_out_full <= w_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.violation  = r_out_viol;
    assign o_out.store_full = r_out_full;

`ifndef SYNTHESIS
    a_viol_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.violation && o_out.store_full))
        else $error("violation and store_full both set");

    a_record_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.record |-> (!w_sts.hit && !w_sts.full))
        else $error("record on a hit or a full store");

    a_begin_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> !w_sts.full)
        else $error("store still full after begin step");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with result register empty");
`endif

endmodule
